### design/i2cbs_pkg.sv
package i2cbs_pkg;

  localparam int MAX_BURST = 128;
  localparam int BUF_AW    = $clog2(MAX_BURST);
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 8;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_AW     = $clog2(OQ_DEPTH);

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LAST_REGISTER = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_RETRY_LIMIT   = 2'd2;

  // commands
  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_BEGIN_WR   = 3'd1;
  localparam logic [2:0] CMD_BEGIN_RD   = 3'd2;
  localparam logic [2:0] CMD_PHASE_OK   = 3'd3;
  localparam logic [2:0] CMD_PHASE_FAIL = 3'd4;
  localparam logic [2:0] CMD_BYTE_RX    = 3'd5;

  // actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_RESTART = 3'd4;
  localparam logic [2:0] ACT_DELIVER = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic [6:0] byte_index;
    logic       done_res;
    logic       success;
    logic       last;
  } res_t;

  // results of one input item: one or two
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } grp_t;

  function automatic res_t mk_res(logic [2:0] act, logic [7:0] byte_val,
                                  logic [6:0] idx, logic done, logic ok);
    res_t r;
    r.action     = act;
    r.bus_byte   = byte_val;
    r.byte_index = idx;
    r.done_res   = done;
    r.success    = done & ok;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

### design/i2cbs_ifs.sv
interface i2cbs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] reg_address;
  logic [7:0] length;
  logic [7:0] data_byte;
  logic [6:0] write_index;

  modport source (output valid, command, reg_address, length, data_byte, write_index,
                  input ready);
  modport sink (input valid, command, reg_address, length, data_byte, write_index,
                output ready);
endinterface

interface i2cbs_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] bus_byte;
  logic [6:0] byte_index;
  logic       done_res;
  logic       success;
  logic       last;

  modport source (output valid, action, bus_byte, byte_index, done_res, success, last,
                  input ready);
  modport sink (input valid, action, bus_byte, byte_index, done_res, success, last,
                output ready);
endinterface

### design/i2cbs_ram.sv
module i2cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/i2c_register_burst_sequencer_unit.sv
// A result is registered in stage 1, then queued, before it appears on rsp.
// Throughput: one input beat per cycle; one result beat per cycle while rsp.ready is
// high, so an item with two results takes two beats. Input stalls only when the queued
// groups plus the one in stage 1 fill the four-entry result queue under backpressure.
// Reset: control state and config registers return to defaults; the write buffer
// is not cleared and holds garbage until loaded.
module i2c_register_burst_sequencer_unit import i2cbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  i2cbs_req_if.sink         req,
  i2cbs_rsp_if.source       rsp
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_REG     = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_RESTART = 3'd4;
  localparam logic [2:0] PH_RECV    = 3'd5;

  logic [6:0] slave_address;
  logic [7:0] last_register;
  logic [3:0] retry_limit;

  logic [2:0] phase, phase_next;
  logic       is_read, is_read_next;
  logic [3:0] attempts, attempts_next;
  logic [7:0] start_register, start_register_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] position, position_next;

  grp_t              grp;
  logic              has_res;
  logic              use_ram;
  logic              acc;
  logic              buf_we;
  logic [BUF_AW-1:0] buf_raddr;
  logic [7:0]        buf_rdata;

  logic       s1_valid;
  grp_t       s1_grp;
  logic       s1_ram;
  grp_t       push_grp;

  grp_t             oq [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr, rptr;
  logic [OQ_AW:0]   count;
  logic             sel;
  logic             pop;
  logic             pop_grp;
  res_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 7'd104;
      last_register <= 8'd126;
      retry_limit   <= 4'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS: slave_address <= cfg_data[6:0];
        CFG_LAST_REGISTER: last_register <= cfg_data[7:0];
        CFG_RETRY_LIMIT:   retry_limit   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // leave room for the group in stage 1 and the one taken now
  assign req.ready = ({1'b0, count} + {{(OQ_AW+1){1'b0}}, s1_valid})
                     <= (OQ_AW+2)'(OQ_DEPTH - 1);
  assign acc       = req.valid && req.ready;
  assign buf_we    = acc && (req.command == CMD_LOAD)
                     && ({1'b0, req.write_index} < 8'(MAX_BURST));

  always_comb begin
    logic [8:0] reg_end;
    logic [8:0] reg_lim;
    logic [7:0] pos_inc;
    logic [3:0] att_inc;
    logic       bad;

    phase_next          = phase;
    is_read_next        = is_read;
    attempts_next       = attempts;
    start_register_next = start_register;
    byte_count_next     = byte_count;
    position_next       = position;
    grp                 = '0;
    has_res             = 1'b0;
    use_ram             = 1'b0;
    buf_raddr           = '0;

    reg_end = {1'b0, req.reg_address} + {1'b0, req.length};
    reg_lim = {1'b0, last_register} + 9'd1;
    pos_inc = position + 8'd1;
    att_inc = attempts + 4'd1;
    bad     = (req.length == 8'd0) || ({1'b0, req.length} > 9'(MAX_BURST))
              || (req.reg_address > last_register) || (reg_end > reg_lim);

    case (req.command)
      CMD_BEGIN_WR, CMD_BEGIN_RD: begin
        if (phase == PH_IDLE) begin
          has_res = 1'b1;
          if (bad) begin
            grp.r0 = mk_res(ACT_NONE, 8'd0, 7'd0, 1'b1, 1'b0);
          end else begin
            is_read_next        = (req.command == CMD_BEGIN_RD);
            start_register_next = req.reg_address;
            byte_count_next     = req.length;
            position_next       = 8'd0;
            attempts_next       = 4'd0;
            if (retry_limit != 4'd0) begin
              phase_next = PH_START;
              grp.r0     = mk_res(ACT_START, {1'b0, slave_address}, 7'd0, 1'b0, 1'b0);
            end else begin
              grp.r0 = mk_res(ACT_STOP, 8'd0, 7'd0, 1'b1, 1'b0);
            end
          end
        end
      end
      CMD_PHASE_OK: begin
        case (phase)
          PH_START: begin
            phase_next = PH_REG;
            has_res    = 1'b1;
            grp.r0     = mk_res(ACT_SEND, start_register, 7'd0, 1'b0, 1'b0);
          end
          PH_REG: begin
            has_res = 1'b1;
            if (is_read) begin
              phase_next = PH_RESTART;
              grp.r0     = mk_res(ACT_RESTART, {1'b0, slave_address}, 7'd0, 1'b0, 1'b0);
            end else begin
              position_next = 8'd0;
              phase_next    = PH_DATA;
              use_ram       = 1'b1;
              buf_raddr     = '0;
              grp.r0        = mk_res(ACT_SEND, 8'd0, 7'd0, 1'b0, 1'b0);
            end
          end
          PH_DATA: begin
            position_next = pos_inc;
            has_res       = 1'b1;
            if (pos_inc < byte_count) begin
              use_ram   = 1'b1;
              buf_raddr = pos_inc[BUF_AW-1:0];
              grp.r0    = mk_res(ACT_SEND, 8'd0, pos_inc[6:0], 1'b0, 1'b0);
            end else begin
              phase_next = PH_IDLE;
              grp.r0     = mk_res(ACT_STOP, 8'd0, 7'd0, 1'b1, 1'b1);
            end
          end
          PH_RESTART: begin
            position_next = 8'd0;
            phase_next    = PH_RECV;
            if (byte_count <= 8'd1) begin
              has_res = 1'b1;
              grp.r0  = mk_res(ACT_STOP, 8'd0, 7'd0, 1'b0, 1'b0);
            end
          end
          default: ;
        endcase
      end
      CMD_PHASE_FAIL: begin
        if (phase == PH_START) begin
          has_res       = 1'b1;
          grp.two       = 1'b1;
          attempts_next = att_inc;
          grp.r0        = mk_res(ACT_STOP, 8'd0, 7'd0, 1'b0, 1'b0);
          if (att_inc < retry_limit) begin
            grp.r1 = mk_res(ACT_START, {1'b0, slave_address}, 7'd0, 1'b0, 1'b0);
          end else begin
            phase_next = PH_IDLE;
            grp.r1     = mk_res(ACT_STOP, 8'd0, 7'd0, 1'b1, 1'b0);
          end
        end else if (phase == PH_REG || phase == PH_DATA || phase == PH_RESTART) begin
          has_res    = 1'b1;
          phase_next = PH_IDLE;
          grp.r0     = mk_res(ACT_STOP, 8'd0, 7'd0, 1'b1, 1'b0);
        end
      end
      CMD_BYTE_RX: begin
        if (phase == PH_RECV) begin
          has_res       = 1'b1;
          position_next = pos_inc;
          if (pos_inc >= byte_count) begin
            phase_next = PH_IDLE;
            grp.r0     = mk_res(ACT_DELIVER, req.data_byte, position[6:0], 1'b1, 1'b1);
          end else begin
            grp.r0 = mk_res(ACT_DELIVER, req.data_byte, position[6:0], 1'b0, 1'b0);
            if (({1'b0, pos_inc} + 9'd1) == {1'b0, byte_count}) begin
              grp.two = 1'b1;
              grp.r1  = mk_res(ACT_STOP, 8'd0, 7'd0, 1'b0, 1'b0);
            end
          end
        end
      end
      default: ;
    endcase

    if (grp.two) begin
      grp.r1.last = 1'b1;
    end else begin
      grp.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_read        <= 1'b0;
      attempts       <= 4'd0;
      start_register <= 8'd0;
      byte_count     <= 8'd0;
      position       <= 8'd0;
    end else if (acc) begin
      phase          <= phase_next;
      is_read        <= is_read_next;
      attempts       <= attempts_next;
      start_register <= start_register_next;
      byte_count     <= byte_count_next;
      position       <= position_next;
    end
  end

  // a load lands at the edge before any later read, so no forwarding is needed
  i2cbs_ram #(.WIDTH(8), .DEPTH(MAX_BURST)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (req.write_index[BUF_AW-1:0]),
    .wdata (req.data_byte),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc && has_res;
    end
    s1_grp <= grp;
    s1_ram <= use_ram;
  end

  always_comb begin
    push_grp = s1_grp;
    if (s1_ram) begin
      push_grp.r0.bus_byte = buf_rdata;
    end
  end

  assign head    = sel ? oq[rptr].r1 : oq[rptr].r0;
  assign pop     = rsp.valid && rsp.ready;
  assign pop_grp = pop && (sel || !oq[rptr].two);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq[wptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      sel   <= 1'b0;
    end else begin
      if (s1_valid) begin
        wptr <= wptr + OQ_AW'(1);
      end
      if (pop_grp) begin
        rptr <= rptr + OQ_AW'(1);
        sel  <= 1'b0;
      end else if (pop) begin
        sel <= 1'b1;
      end
      count <= count + (OQ_AW+1)'(s1_valid) - (OQ_AW+1)'(pop_grp);
    end
  end

  assign rsp.valid      = (count != '0);
  assign rsp.action     = head.action;
  assign rsp.bus_byte   = head.bus_byte;
  assign rsp.byte_index = head.byte_index;
  assign rsp.done_res   = head.done_res;
  assign rsp.success    = head.success;
  assign rsp.last       = head.last;

endmodule

### design/i2cbs_checker.sv
module i2cbs_checker import i2cbs_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_action,
  input logic [7:0] rsp_bus_byte,
  input logic [6:0] rsp_byte_index,
  input logic       rsp_done_res,
  input logic       rsp_success,
  input logic       rsp_last
);

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_action)
      && $stable(rsp_bus_byte) && $stable(rsp_byte_index) && $stable(rsp_done_res)
      && $stable(rsp_success) && $stable(rsp_last)))
    else $error("result beat changed while stalled");

  // a finishing result closes its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_done_res) |-> rsp_last)
    else $error("done result not marked last");

  a_success_kind: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_success) |-> (rsp_done_res
      && (rsp_action == ACT_STOP || rsp_action == ACT_DELIVER)))
    else $error("success on wrong result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!rsp_valid && req_ready))
    else $error("output not empty after reset");

endmodule

bind i2c_register_burst_sequencer_unit i2cbs_checker u_i2cbs_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_action     (rsp.action),
  .rsp_bus_byte   (rsp.bus_byte),
  .rsp_byte_index (rsp.byte_index),
  .rsp_done_res   (rsp.done_res),
  .rsp_success    (rsp.success),
  .rsp_last       (rsp.last)
);

### verif/tb_i2c_register_burst_sequencer_unit.sv
module tb_i2c_register_burst_sequencer_unit;
  import i2cbs_pkg::*;

  localparam int         RUN_LIMIT     = 400000;
  localparam int         PRESSURE_HOLD = 120;
  localparam logic [2:0] CMD_SPARE6    = 3'd6;
  localparam logic [2:0] CMD_SPARE7    = 3'd7;

  typedef enum logic [2:0] {
    BP_IDLE, BP_START, BP_REG, BP_DATA, BP_RESTART, BP_RECV
  } burst_phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] reg_address;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic [6:0] write_index;
  } bus_event_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  i2cbs_req_if req_if ();
  i2cbs_rsp_if rsp_if ();

  i2c_register_burst_sequencer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus and expectations
  bus_event_t events_to_send[$];
  res_t       bus_actions_due[$];
  bit         loaded[MAX_BURST];
  int         n_queued   = 0;
  int         n_in       = 0;
  int         n_checked  = 0;
  int         n_done     = 0;
  int         n_success  = 0;
  int         mismatches = 0;
  int         n_added;
  int         idle_pct   = 0;
  int         stall_pct  = 0;
  int         hold_left  = 0;
  bit         hold_req   = 1'b0;

  // sequencer copy: settings and burst state
  logic [6:0]   tgt_addr;
  logic [7:0]   top_reg;
  logic [3:0]   start_budget;
  burst_phase_t ph        = BP_IDLE;
  bit           rd_burst  = 1'b0;
  logic [3:0]   tries     = 4'd0;
  logic [7:0]   first_reg = 8'd0;
  logic [7:0]   burst_len = 8'd0;
  logic [7:0]   pos       = 8'd0;
  logic [7:0]   wbuf[MAX_BURST];

  task automatic note_action(input logic [2:0] act, input logic [7:0] b,
                             input logic [6:0] idx, input logic done, input logic ok);
    res_t r;
    r.action     = act;
    r.bus_byte   = b;
    r.byte_index = idx;
    r.done_res   = done;
    r.success    = done & ok;
    r.last       = 1'b0;
    bus_actions_due.push_back(r);
    n_added++;
  endtask

  task automatic fail_burst();
    ph = BP_IDLE;
    note_action(ACT_STOP, 8'd0, 7'd0, 1'b1, 1'b0);
  endtask

  task automatic attempt_start();
    if (tries < start_budget) begin
      ph = BP_START;
      note_action(ACT_START, {1'b0, tgt_addr}, 7'd0, 1'b0, 1'b0);
    end else begin
      fail_burst();
    end
  endtask

  task automatic predict_bus_actions(input bus_event_t ev);
    res_t r;
    logic [6:0] idx;
    n_added = 0;
    case (ev.command)
      CMD_LOAD: wbuf[ev.write_index] = ev.data_byte;
      CMD_BEGIN_WR, CMD_BEGIN_RD: begin
        if (ph == BP_IDLE) begin
          if (ev.length == 8'd0 || int'(ev.length) > MAX_BURST || ev.reg_address > top_reg ||
              int'(ev.reg_address) + int'(ev.length) > int'(top_reg) + 1) begin
            note_action(ACT_NONE, 8'd0, 7'd0, 1'b1, 1'b0);
          end else begin
            rd_burst  = (ev.command == CMD_BEGIN_RD);
            first_reg = ev.reg_address;
            burst_len = ev.length;
            pos       = 8'd0;
            tries     = 4'd0;
            attempt_start();
          end
        end
      end
      CMD_PHASE_OK: begin
        case (ph)
          BP_START: begin
            ph = BP_REG;
            note_action(ACT_SEND, first_reg, 7'd0, 1'b0, 1'b0);
          end
          BP_REG: begin
            if (rd_burst) begin
              ph = BP_RESTART;
              note_action(ACT_RESTART, {1'b0, tgt_addr}, 7'd0, 1'b0, 1'b0);
            end else begin
              pos = 8'd0;
              ph  = BP_DATA;
              note_action(ACT_SEND, wbuf[0], 7'd0, 1'b0, 1'b0);
            end
          end
          BP_DATA: begin
            pos = pos + 8'd1;
            if (pos < burst_len) begin
              note_action(ACT_SEND, wbuf[pos[6:0]], pos[6:0], 1'b0, 1'b0);
            end else begin
              ph = BP_IDLE;
              note_action(ACT_STOP, 8'd0, 7'd0, 1'b1, 1'b1);
            end
          end
          BP_RESTART: begin
            pos = 8'd0;
            ph  = BP_RECV;
            if (burst_len <= 8'd1) note_action(ACT_STOP, 8'd0, 7'd0, 1'b0, 1'b0);
          end
          default: ;
        endcase
      end
      CMD_PHASE_FAIL: begin
        if (ph == BP_START) begin
          note_action(ACT_STOP, 8'd0, 7'd0, 1'b0, 1'b0);
          tries = tries + 4'd1;
          attempt_start();
        end else if (ph == BP_REG || ph == BP_DATA || ph == BP_RESTART) begin
          fail_burst();
        end
      end
      CMD_BYTE_RX: begin
        if (ph == BP_RECV) begin
          idx = pos[6:0];
          pos = pos + 8'd1;
          if (pos >= burst_len) begin
            ph = BP_IDLE;
            note_action(ACT_DELIVER, ev.data_byte, idx, 1'b1, 1'b1);
          end else begin
            note_action(ACT_DELIVER, ev.data_byte, idx, 1'b0, 1'b0);
            // ask for the stop before the final byte arrives
            if (int'(pos) + 1 == int'(burst_len)) note_action(ACT_STOP, 8'd0, 7'd0, 1'b0, 1'b0);
          end
        end
      end
      default: ;
    endcase
    if (n_added > 0) begin
      r = bus_actions_due.pop_back();
      r.last = 1'b1;
      bus_actions_due.push_back(r);
    end
  endtask

  // request driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin : drive_req
    bus_event_t ev;
    if (rst) begin
      req_if.valid       <= 1'b0;
      req_if.command     <= CMD_LOAD;
      req_if.reg_address <= 8'd0;
      req_if.length      <= 8'd0;
      req_if.data_byte   <= 8'd0;
      req_if.write_index <= 7'd0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        ev.command     = req_if.command;
        ev.reg_address = req_if.reg_address;
        ev.length      = req_if.length;
        ev.data_byte   = req_if.data_byte;
        ev.write_index = req_if.write_index;
        predict_bus_actions(ev);
        n_in++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (events_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          ev = events_to_send.pop_front();
          req_if.valid       <= 1'b1;
          req_if.command     <= ev.command;
          req_if.reg_address <= ev.reg_address;
          req_if.length      <= ev.length;
          req_if.data_byte   <= ev.data_byte;
          req_if.write_index <= ev.write_index;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= PRESSURE_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) rsp_if.ready <= 1'b0;
    else if (hold_left != 0) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : check_rsp
    res_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (bus_actions_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got action %0h byte %0h",
                 $time, rsp_if.action, rsp_if.bus_byte);
      end else begin
        want = bus_actions_due.pop_front();
        check_field("action", 8'(want.action), 8'(rsp_if.action));
        check_field("bus_byte", want.bus_byte, rsp_if.bus_byte);
        check_field("byte_index", 8'(want.byte_index), 8'(rsp_if.byte_index));
        check_field("done_res", 8'(want.done_res), 8'(rsp_if.done_res));
        check_field("success", 8'(want.success), 8'(rsp_if.success));
        check_field("last", 8'(want.last), 8'(rsp_if.last));
        n_checked++;
        if (want.done_res) n_done++;
        if (want.success) n_success++;
      end
    end
  end

  // stimulus helpers

  task automatic push_event(input logic [2:0] cmd, input logic [7:0] ra, input logic [7:0] len,
                            input logic [7:0] dat, input logic [6:0] widx);
    bus_event_t ev;
    // a write burst must never read an entry that was not loaded
    if (cmd == CMD_BEGIN_WR && int'(len) <= MAX_BURST) begin
      for (int i = 0; i < int'(len); i++) begin
        if (!loaded[i]) push_event(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 7'(i));
      end
    end
    if (cmd == CMD_LOAD) loaded[widx] = 1'b1;
    ev.command     = cmd;
    ev.reg_address = ra;
    ev.length      = len;
    ev.data_byte   = dat;
    ev.write_index = widx;
    events_to_send.push_back(ev);
    n_queued++;
  endtask

  task automatic push_cmd(input logic [2:0] cmd);
    push_event(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom));
  endtask

  // number of failed starts to queue; the whole budget ends the burst
  function automatic int start_failures(input bit clean);
    if (clean || $urandom_range(99) < 60) return 0;
    return $urandom_range(1, start_budget);
  endfunction

  task automatic queue_write_burst(input logic [7:0] ra, input logic [7:0] len, input bit clean);
    int f;
    push_event(CMD_BEGIN_WR, ra, len, 8'($urandom), 7'($urandom));
    if (start_budget == 4'd0) return;
    f = start_failures(clean);
    repeat (f) push_cmd(CMD_PHASE_FAIL);
    if (f == int'(start_budget)) return;
    push_cmd(CMD_PHASE_OK);
    if (!clean && $urandom_range(99) < 10) begin
      push_cmd(CMD_PHASE_FAIL);
      return;
    end
    push_cmd(CMD_PHASE_OK);
    for (int i = 0; i < int'(len); i++) begin
      if (!clean && $urandom_range(99) < 8) push_cmd(CMD_LOAD);
      if (!clean && $urandom_range(99) < 4) begin
        push_cmd(CMD_PHASE_FAIL);
        return;
      end
      push_cmd(CMD_PHASE_OK);
    end
  endtask

  task automatic queue_read_burst(input logic [7:0] ra, input logic [7:0] len, input bit clean);
    int f;
    push_event(CMD_BEGIN_RD, ra, len, 8'($urandom), 7'($urandom));
    if (start_budget == 4'd0) return;
    f = start_failures(clean);
    repeat (f) push_cmd(CMD_PHASE_FAIL);
    if (f == int'(start_budget)) return;
    push_cmd(CMD_PHASE_OK);
    for (int i = 0; i < 2; i++) begin
      if (!clean && $urandom_range(99) < 10) begin
        push_cmd(CMD_PHASE_FAIL);
        return;
      end
      push_cmd(CMD_PHASE_OK);
    end
    for (int i = 0; i < int'(len); i++) begin
      // stray phase reports while receiving are dropped by the block
      if (!clean && $urandom_range(99) < 6) push_cmd($urandom_range(1) ? CMD_PHASE_OK : CMD_PHASE_FAIL);
      push_cmd(CMD_BYTE_RX);
    end
  endtask

  task automatic queue_rejected_begin();
    logic [2:0] cmd;
    int ra, len, need;
    cmd = $urandom_range(1) ? CMD_BEGIN_WR : CMD_BEGIN_RD;
    ra  = $urandom_range(255);
    case ($urandom_range(3))
      0: len = 0;
      1: len = $urandom_range(MAX_BURST + 1, 255);
      2: begin
        if (top_reg < 8'd255) begin
          ra  = $urandom_range(int'(top_reg) + 1, 255);
          len = $urandom_range(1, MAX_BURST);
        end else begin
          len = 0;
        end
      end
      default: begin
        ra   = $urandom_range(0, int'(top_reg));
        need = int'(top_reg) - ra + 2;
        len  = (need > MAX_BURST) ? $urandom_range(MAX_BURST + 1, 255)
                                  : $urandom_range(need, MAX_BURST);
      end
    endcase
    push_event(cmd, ra[7:0], len[7:0], 8'($urandom), 7'($urandom));
  endtask

  task automatic queue_burst_batch(input int n);
    int goal, pick, room, len, ra;
    goal = n_queued + n;
    while (n_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len  = ($urandom_range(99) < 88) ? $urandom_range(1, 6) : $urandom_range(7, 32);
        room = int'(top_reg) + 1;
        if (len > room) len = room;
        ra = $urandom_range(0, room - len);
        if (pick < 35) queue_write_burst(ra[7:0], len[7:0], 1'b0);
        else queue_read_burst(ra[7:0], len[7:0], 1'b0);
      end else if (pick < 85) begin
        queue_rejected_begin();
      end else begin
        repeat ($urandom_range(1, 3)) push_cmd(3'($urandom_range(7)));
      end
    end
  endtask

  task automatic wait_drain();
    while (events_to_send.size() != 0 || req_if.valid || bus_actions_due.size() != 0)
      @(negedge clk);
    // let beats that cause no result clear the pipeline
    repeat (6) @(negedge clk);
  endtask

  // drain and bring any open burst back to idle
  task automatic close_phase();
    wait_drain();
    while (ph != BP_IDLE) begin
      if (ph == BP_RECV) push_cmd(CMD_BYTE_RX);
      else if (ph == BP_START) push_cmd(CMD_PHASE_OK);
      else push_cmd(CMD_PHASE_FAIL);
      wait_drain();
    end
  endtask

  task automatic write_cfg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_target(input logic [6:0] a, input logic [7:0] top,
                                input logic [3:0] budget);
    write_cfg(CFG_SLAVE_ADDRESS, {1'b0, a});
    write_cfg(CFG_LAST_REGISTER, top);
    write_cfg(CFG_RETRY_LIMIT, {4'd0, budget});
    tgt_addr     = a;
    top_reg      = top;
    start_budget = budget;
    @(negedge clk);
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d result beats still due", bus_actions_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    tgt_addr           = 7'd104;
    top_reg            = 8'd126;
    start_budget       = 4'd5;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, no idling: directed beats first
    push_event(CMD_LOAD, 8'd0, 8'd0, 8'h00, 7'd0);
    push_event(CMD_LOAD, 8'd0, 8'd0, 8'hff, 7'd127);
    push_event(CMD_LOAD, 8'd0, 8'd0, 8'ha5, 7'd1);
    push_event(CMD_BEGIN_WR, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_BEGIN_WR, 8'd0, 8'd255, 8'd0, 7'd0);
    push_event(CMD_BEGIN_RD, 8'd127, 8'd1, 8'd0, 7'd0);
    push_event(CMD_BEGIN_WR, 8'd126, 8'd2, 8'd0, 7'd0);
    push_event(CMD_BEGIN_WR, 8'd125, 8'd2, 8'd0, 7'd0);
    push_event(CMD_PHASE_FAIL, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_BEGIN_RD, 8'd0, 8'd1, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'hff, 8'hff, 8'hff, 7'h7f);
    push_event(CMD_PHASE_FAIL, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_BYTE_RX, 8'd0, 8'd0, 8'h3c, 7'd0);
    push_event(CMD_SPARE6, 8'hff, 8'd1, 8'hff, 7'h7f);
    push_event(CMD_SPARE7, 8'd0, 8'd1, 8'd0, 7'd0);
    push_event(CMD_BEGIN_RD, 8'd0, 8'd1, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_OK, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_PHASE_FAIL, 8'd0, 8'd0, 8'd0, 7'd0);
    push_event(CMD_BYTE_RX, 8'd0, 8'd0, 8'hff, 7'd0);
    queue_burst_batch(10);
    close_phase();

    // widest settings, sparse sender, a full-size burst that ends at the top of the map
    program_target(7'h7f, 8'd255, 4'd15);
    idle_pct = 65;
    push_event(CMD_BEGIN_RD, 8'd128, 8'd128, 8'd0, 7'd0);
    push_cmd(CMD_PHASE_OK);
    push_cmd(CMD_PHASE_FAIL);
    queue_burst_batch(10);
    close_phase();

    // narrowest map, single start attempt, slow receiver
    program_target(7'h00, 8'd0, 4'd1);
    idle_pct  = 0;
    stall_pct = 65;
    queue_burst_batch(8);
    close_phase();

    // start never tried
    program_target(7'($urandom), 8'($urandom_range(64, 200)), 4'd0);
    idle_pct  = 10;
    stall_pct = 10;
    queue_burst_batch(6);
    close_phase();

    // hold the receiver off while a read burst keeps coming
    program_target(7'h2a, 8'd200, 4'd3);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    queue_read_burst(8'd10, 8'd12, 1'b1);
    @(negedge clk);
    hold_req = 1'b0;
    queue_burst_batch(6);
    wait_drain();

    $display("ran %0d request beats and checked %0d result beats over five register settings",
             n_in, n_checked);
    $display("%0d bursts closed, %0d with success, %0d mismatches",
             n_done, n_success, mismatches);
    if (mismatches == 0 && bus_actions_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
design/i2cbs_pkg.sv
design/i2cbs_ifs.sv
design/i2cbs_ram.sv
design/i2c_register_burst_sequencer_unit.sv
design/i2cbs_checker.sv
verif/tb_i2c_register_burst_sequencer_unit.sv
